### src/seq_pkg.sv
// shared types and constants of the sorted event queue
// no dependencies
package seq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned TIME_BITS_DEF   = 48;

  typedef enum logic [2:0] {
    FN_INS_TIME   = 3'd0,
    FN_INS_BEFORE = 3'd1,
    FN_INS_AFTER  = 3'd2,
    FN_REMOVE     = 3'd3,
    FN_CLEAR      = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_SCHEDULED   = 3'd2,
    ST_NO_REF      = 3'd3,
    ST_NO_PROC     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TS_NEW,
    TS_OWN,
    TS_LEFT
  } tsel_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_APPLY
  } fsm_e;

  typedef struct packed {
    logic  ins;
    logic  rem;
    tsel_e tsel;
  } apply_t;

endpackage

### src/seq_prefix.sv
// inclusive prefix or over a flag vector, log-depth network
// depends on nothing but its parameter
module seq_prefix #(
  parameter int unsigned N = 64
) (
  input  logic [N-1:0] flags_i,
  output logic [N-1:0] prefix_o
);

  localparam int unsigned L = $clog2(N);

  logic [N-1:0] lvl [L+1];

  assign lvl[0] = flags_i;

  for (genvar k = 0; k < L; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign prefix_o = lvl[L];

endmodule

### src/seq_cell.sv
// one slot of the sorted event queue: compares against the pending item,
// then keeps, shifts in from a neighbor or takes the new entry; uses seq_pkg
module seq_cell import seq_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 valid_i,
  input  logic                 eval_i,
  input  logic [7:0]           id_i,
  input  logic [7:0]           ref_i,
  input  logic [TIME_BITS-1:0] time_i,
  input  apply_t               apply_i,
  input  logic                 gap_i,
  input  logic                 gap_prev_i,
  input  logic                 rem_i,
  input  logic [7:0]           left_proc_i,
  input  logic [TIME_BITS-1:0] left_time_i,
  input  logic [7:0]           right_proc_i,
  input  logic [TIME_BITS-1:0] right_time_i,
  output logic [7:0]           proc_o,
  output logic [TIME_BITS-1:0] time_o,
  output logic                 match_id_o,
  output logic                 match_ref_o,
  output logic                 ge_o
);

  logic [7:0]           proc_q, proc_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic                 mid_q, mref_q, ge_q;

  always_ff @(posedge clk_i) begin
    proc_q <= proc_d;
    time_q <= time_d;
    if (eval_i) begin
      mid_q  <= valid_i && (proc_q == id_i);
      mref_q <= valid_i && (proc_q == ref_i);
      ge_q   <= !valid_i || (time_q >= time_i);
    end
  end

  always_comb begin
    proc_d = proc_q;
    time_d = time_q;
    if (apply_i.ins) begin
      if (gap_i && !gap_prev_i) begin
        proc_d = id_i;
        case (apply_i.tsel)
          TS_NEW:  time_d = time_i;
          TS_OWN:  time_d = time_q;
          TS_LEFT: time_d = left_time_i;
          default: time_d = time_i;
        endcase
      end else if (gap_prev_i) begin
        proc_d = left_proc_i;
        time_d = left_time_i;
      end
    end else if (apply_i.rem && rem_i) begin
      proc_d = right_proc_i;
      time_d = right_time_i;
    end
  end

  assign proc_o      = proc_q;
  assign time_o      = time_q;
  assign match_id_o  = mid_q;
  assign match_ref_o = mref_q;
  assign ge_o        = ge_q;

endmodule

### src/sorted_event_queue.sv
// sorted event queue: a row of slot cells kept in order of event time
// each operation passes a compare state (EVAL), then a shift state (APPLY) that registers the result strobe
// a new request is taken during the shift phase of the last one, but not during its compare phase
// reset clears the entry count, the state and the result strobe; slot contents are undefined until written
// results are shown for one cycle; the receiver cannot stall
// depends on seq_pkg, seq_cell and seq_prefix
module sorted_event_queue import seq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = TIME_BITS_DEF,
  localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [2:0]           func_i,
  input  logic [7:0]           proc_id_i,
  input  logic [TIME_BITS-1:0] event_time_i,
  input  logic [7:0]           ref_proc_id_i,
  output logic                 result_valid_o,
  output logic [2:0]           status_o,
  output logic [TIME_BITS-1:0] given_time_o,
  output logic                 head_valid_o,
  output logic [7:0]           head_proc_o,
  output logic [TIME_BITS-1:0] head_time_o,
  output logic [CW-1:0]        entry_count_o
);

  localparam int unsigned N = QUEUE_DEPTH;

  fsm_e state_q, state_d;
  logic accept;

  logic [2:0]           func_q;
  logic [7:0]           id_q, ref_q;
  logic [TIME_BITS-1:0] time_q;

  logic [CW-1:0]        count_q, count_d;
  logic [2:0]           status_q, status_d;
  logic [TIME_BITS-1:0] given_q, given_d;
  logic                 strobe_q, strobe_d;

  logic [7:0]           proc_w [N];
  logic [TIME_BITS-1:0] time_w [N];
  logic [N-1:0]         mid, mref, ge, pref_id, pref_ref, gap, gap_prev;
  logic [TIME_BITS-1:0] ref_time;
  logic                 full, id_found, ref_found;
  apply_t               apply;

  assign busy_o = (state_q == FSM_EVAL);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      id_q   <= proc_id_i;
      ref_q  <= ref_proc_id_i;
      time_q <= event_time_i;
    end
    status_q <= status_d;
    given_q  <= given_d;
  end

  // slot row
  for (genvar i = 0; i < N; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic [7:0]           lp, rp;
    logic [TIME_BITS-1:0] lt, rt;
    if (i == 0) begin : g_first
      assign lp = '0;
      assign lt = '0;
    end else begin : g_left
      assign lp = proc_w[i-1];
      assign lt = time_w[i-1];
    end
    if (i == N - 1) begin : g_last
      assign rp = '0;
      assign rt = '0;
    end else begin : g_right
      assign rp = proc_w[i+1];
      assign rt = time_w[i+1];
    end
    seq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .valid_i     (count_q > IDX),
      .eval_i      (state_q == FSM_EVAL),
      .id_i        (id_q),
      .ref_i       (ref_q),
      .time_i      (time_q),
      .apply_i     (apply),
      .gap_i       (gap[i]),
      .gap_prev_i  (gap_prev[i]),
      .rem_i       (pref_id[i]),
      .left_proc_i (lp),
      .left_time_i (lt),
      .right_proc_i(rp),
      .right_time_i(rt),
      .proc_o      (proc_w[i]),
      .time_o      (time_w[i]),
      .match_id_o  (mid[i]),
      .match_ref_o (mref[i]),
      .ge_o        (ge[i])
    );
  end

  seq_prefix #(.N(N)) u_pref_id  (.flags_i(mid),  .prefix_o(pref_id));
  seq_prefix #(.N(N)) u_pref_ref (.flags_i(mref), .prefix_o(pref_ref));

  assign id_found  = pref_id[N-1];
  assign ref_found = pref_ref[N-1];
  assign full      = (count_q == CW'(QUEUE_DEPTH));

  always_comb begin
    ref_time = '0;
    for (int i = 0; i < N; i++) begin
      if (mref[i]) begin
        ref_time = ref_time | time_w[i];
      end
    end
  end

  always_comb begin
    case (func_q)
      FN_INS_TIME:   gap = ge;
      FN_INS_BEFORE: gap = pref_ref;
      FN_INS_AFTER:  gap = {pref_ref[N-2:0], 1'b0};
      default:       gap = '0;
    endcase
  end

  assign gap_prev = {gap[N-2:0], 1'b0};

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    status_d   = status_q;
    given_d    = given_q;
    strobe_d   = 1'b0;
    apply.ins  = 1'b0;
    apply.rem  = 1'b0;
    apply.tsel = TS_NEW;
    case (func_q)
      FN_INS_BEFORE: apply.tsel = TS_OWN;
      FN_INS_AFTER:  apply.tsel = TS_LEFT;
      default:       apply.tsel = TS_NEW;
    endcase
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EVAL;
        end
      end
      FSM_EVAL: begin
        state_d = FSM_APPLY;
      end
      FSM_APPLY: begin
        state_d  = accept ? FSM_EVAL : FSM_IDLE;
        strobe_d = 1'b1;
        status_d = ST_OK;
        given_d  = '0;
        case (func_q)
          FN_INS_TIME, FN_INS_BEFORE, FN_INS_AFTER: begin
            if (id_found) begin
              status_d = ST_SCHEDULED;
            end else if (func_q != FN_INS_TIME && !ref_found) begin
              status_d = ST_NO_REF;
            end else if (full) begin
              status_d = ST_FULL;
            end else begin
              apply.ins = 1'b1;
              count_d   = count_q + 1'b1;
              given_d   = (func_q == FN_INS_TIME) ? time_q : ref_time;
            end
          end
          FN_REMOVE: begin
            if (id_found) begin
              apply.rem = 1'b1;
              count_d   = count_q - 1'b1;
            end else begin
              status_d = ST_NO_PROC;
            end
          end
          FN_CLEAR: begin
            count_d = '0;
          end
          default: begin
            status_d = ST_OK;
          end
        endcase
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign result_valid_o = strobe_q;
  assign status_o       = status_q;
  assign given_time_o   = given_q;
  assign head_valid_o   = (count_q != '0);
  assign head_proc_o    = head_valid_o ? proc_w[0] : '0;
  assign head_time_o    = head_valid_o ? time_w[0] : '0;
  assign entry_count_o  = count_q;

endmodule
